/* sv/laas_pkg.sv */
package laas_pkg;

	localparam int MAX_QUERY = 256;
	localparam int SYM_W = 8;
	localparam int QADDR_W = $clog2(MAX_QUERY);
	localparam int QLEN_W = QADDR_W + 1;
	localparam int SCORE_W = 16;

	localparam logic [1:0] REG_MATCH = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP_OPEN = 2'd2;
	localparam logic [1:0] REG_GAP_EXTEND = 2'd3;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_TARGET = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_ROW
	} state_t;

	typedef struct packed {
		logic query_we;
		logic [QADDR_W-1:0] query_addr;
		logic [SYM_W-1:0] sym;
		logic [QADDR_W-1:0] rd_addr;
		logic [QADDR_W-1:0] wr_addr;
		logic row_start;
		logic row_step;
		logic first_row;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_valid;
	} dp_status_t;

	function automatic logic signed [SCORE_W-1:0] sat16(input logic signed [SCORE_W+1:0] x);
		if (x > 18'sd32767) begin
			return 16'sh7fff;
		end else if (x < -18'sd32768) begin
			return 16'sh8000;
		end
		return x[SCORE_W-1:0];
	endfunction

	function automatic logic clipped(input logic signed [SCORE_W+1:0] x);
		return (x > 18'sd32767) || (x < -18'sd32768);
	endfunction

	function automatic logic signed [SCORE_W-1:0] smax(input logic signed [SCORE_W-1:0] a,
			input logic signed [SCORE_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* sv/laas_ram.sv */
module laas_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(D)-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/laas_dp.sv */
module laas_dp import laas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input dp_cmd_t cmd,
	output dp_status_t status,
	input logic m_tready,
	output logic [15:0] m_tdata,
	output logic m_tuser
);

	logic [6:0] match_q;
	logic signed [7:0] mismatch_q, open_q, extend_q;
	logic signed [SCORE_W-1:0] e_q, diag_q, best_q;
	logic sat_q;
	logic out_valid_q;
	logic [14:0] out_score_q;
	logic out_sat_q;

	logic [SYM_W-1:0] qsym;
	logic [2*SCORE_W-1:0] row_rd, row_wr;
	logic signed [SCORE_W-1:0] cell_rd, gap_rd, f, cell_old, sub, open16, ext16;
	logic signed [SCORE_W-1:0] h0, h, t, e_n, g_n, best_n;
	logic signed [SCORE_W+1:0] s1, s2, s3, s4;
	logic sat_n;

	laas_ram #(.W(SYM_W), .D(MAX_QUERY)) u_query (
		.clk(clk), .we(cmd.query_we), .waddr(cmd.query_addr), .wdata(cmd.sym),
		.raddr(cmd.rd_addr), .rdata(qsym)
	);

	laas_ram #(.W(2*SCORE_W), .D(MAX_QUERY)) u_row (
		.clk(clk), .we(cmd.row_step), .waddr(cmd.wr_addr), .wdata(row_wr),
		.raddr(cmd.rd_addr), .rdata(row_rd)
	);

	always_comb begin
		open16 = SCORE_W'(open_q);
		ext16 = SCORE_W'(extend_q);
		cell_rd = row_rd[2*SCORE_W-1:SCORE_W];
		gap_rd = row_rd[SCORE_W-1:0];
		f = cmd.first_row ? open16 : gap_rd;
		cell_old = cmd.first_row ? '0 : cell_rd;
		sub = (qsym == cmd.sym) ? SCORE_W'({1'b0, match_q}) : SCORE_W'(mismatch_q);
		s1 = (SCORE_W+2)'(diag_q) + (SCORE_W+2)'(sub);
		h0 = sat16(s1);
		h = smax(smax(h0, e_q), smax(f, '0));
		s2 = (SCORE_W+2)'(h) + (SCORE_W+2)'(open16);
		t = sat16(s2);
		s3 = (SCORE_W+2)'(e_q) + (SCORE_W+2)'(ext16);
		s4 = (SCORE_W+2)'(f) + (SCORE_W+2)'(ext16);
		e_n = smax(sat16(s3), t);
		g_n = smax(sat16(s4), t);
		row_wr = {h, g_n};
		best_n = best_q;
		sat_n = sat_q;
		if (cmd.row_step) begin
			best_n = smax(best_q, h);
			sat_n = sat_q | clipped(s1) | clipped(s2) | clipped(s3) | clipped(s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 7'd1;
			mismatch_q <= -8'sd4;
			open_q <= -8'sd7;
			extend_q <= -8'sd1;
			best_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MATCH: match_q <= cfg_data[6:0];
					REG_MISMATCH: mismatch_q <= cfg_data;
					REG_GAP_OPEN: open_q <= cfg_data;
					REG_GAP_EXTEND: extend_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				best_q <= '0;
				sat_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				best_q <= best_n;
				sat_q <= sat_n;
				if (m_tready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_start) begin
			e_q <= open16;
			diag_q <= '0;
		end else if (cmd.row_step) begin
			e_q <= e_n;
			diag_q <= cell_old;
		end
		if (cmd.emit) begin
			out_score_q <= best_n[14:0];
			out_sat_q <= sat_n;
		end
	end

	assign status.out_valid = out_valid_q;
	assign m_tdata = {1'b0, out_score_q};
	assign m_tuser = out_sat_q;

endmodule

/* sv/laas_ctrl.sv */
module laas_ctrl import laas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [SYM_W-1:0] s_tdata,
	input logic s_tuser,
	input logic s_tlast,
	input dp_status_t status,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic [QLEN_W-1:0] len_q;
	logic [QADDR_W-1:0] cnt_q;
	logic busy_q, closed_q, first_q, last_q;
	logic [SYM_W-1:0] sym_q;
	logic acc, cell_end;

	assign acc = s_tvalid && s_tready;
	assign cell_end = ({1'b0, cnt_q} == len_q - QLEN_W'(1));

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		cmd = '0;
		cmd.query_addr = len_q[QADDR_W-1:0];
		cmd.wr_addr = cnt_q;
		cmd.first_row = first_q;
		cmd.sym = sym_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = !status.out_valid;
				cmd.rd_addr = '0;
				if (acc) begin
					cmd.sym = s_tdata;
					if (s_tuser == OP_QUERY) begin
						cmd.query_we = !closed_q && !busy_q && (len_q < QLEN_W'(MAX_QUERY));
					end else if (len_q == '0) begin
						cmd.emit = s_tlast;
					end else begin
						cmd.row_start = 1'b1;
						state_d = ST_ROW;
					end
				end
			end
			ST_ROW: begin
				cmd.rd_addr = cnt_q + QADDR_W'(1);
				cmd.row_step = 1'b1;
				if (cell_end) begin
					cmd.emit = last_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			closed_q <= 1'b0;
			first_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.query_we) begin
				len_q <= len_q + QLEN_W'(1);
			end
			if (acc && s_tuser == OP_QUERY && s_tlast) begin
				closed_q <= 1'b1;
			end
			if (acc && s_tuser == OP_TARGET) begin
				first_q <= !busy_q;
				busy_q <= 1'b1;
				closed_q <= 1'b1;
				last_q <= s_tlast;
				cnt_q <= '0;
			end
			if (state_q == ST_ROW) begin
				cnt_q <= cnt_q + QADDR_W'(1);
			end
			if (cmd.emit) begin
				len_q <= '0;
				busy_q <= 1'b0;
				closed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sym_q <= s_tdata;
		end
	end

endmodule

/* sv/local_alignment_affine_score_core.sv */
// score-only local alignment with affine gaps, one pair at a time
// query symbols fill the query memory; a target symbol runs one row, one cell per cycle
// (set by the single read/write port pair of the row memory)
// result is registered at the last cell of the row marked last and appears in the cycle after
// arst_n clears control state and restores default scores; row memory reads are ignored
// during the row of the first target symbol of each pair, which overwrites the row memory
module local_alignment_affine_score_core import laas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,	// symbol
	input logic s_tuser,	// operation
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata,	// score[14:0], zero pad
	output logic m_tuser,	// saturated
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);

	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;
	assign m_tvalid = status.out_valid;

	laas_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata[SYM_W-1:0]), .s_tuser(s_tuser), .s_tlast(s_tlast),
		.status(status), .cmd(cmd)
	);

	laas_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .status(status), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule
